### rtl/sle_pkg.sv
// ============================================================================
// sle_pkg
// Request kinds, status codes and field types for the list engine core.
// ============================================================================
`default_nettype none

package sle_pkg;

  // Request kind carried in the input tuser
  typedef logic [2:0] req_t;

  localparam req_t REQ_INSERT  = 3'd0;
  localparam req_t REQ_DELETE  = 3'd1;
  localparam req_t REQ_LOCATE  = 3'd2;
  localparam req_t REQ_MINMAX  = 3'd3;
  localparam req_t REQ_REVERSE = 3'd4;

  // Result status carried in the output tuser
  typedef logic [1:0] status_t;

  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_RANGE = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;
  localparam status_t STAT_EMPTY = 2'd3;

  // Entry word
  localparam int unsigned DATA_W = 32;
  typedef logic [DATA_W-1:0] word_t;

  // Width of position, found_position and count fields
  localparam int unsigned POS_W = 6;

endpackage

`default_nettype wire

### rtl/sle_ram.sv
// ============================================================================
// sle_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module sle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/sequential_list_engine_core.sv
// ============================================================================
// sequential_list_engine_core
// Fixed-capacity ordered list of signed 32-bit words held in one RAM.
// Serves insert, delete, locate, minmax and reverse requests, one result
// beat per request beat.
// ============================================================================
//
//  channel | dir | tdata                                      | tuser
//  --------+-----+--------------------------------------------+---------------
//  in_     | in  | position[5:0], value[37:6]                 | req_type[2:0]
//  out_    | out | out_value[31:0], out_max[63:32],           | status[1:0]
//          |     | found_position[69:64], count[75:70]        |
//
//  Request duration is set by the single read port of the list RAM.
//  Insert, delete, locate and minmax walk it one entry per cycle;
//  reverse reads both ends of each pair, then writes both back. Rejected
//  or unknown requests go straight to the finish state.
//  Reset clears the entry count and control state; RAM contents are never cleared.
//  One request is in work at a time; a new beat is taken while the previous
//  result still waits in the output register.
// ============================================================================
`default_nettype none

module sequential_list_engine_core #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // position[5:0], value[37:6]
  input  wire logic [2:0]  in_tuser,   // req_type[2:0]

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [79:0] out_tdata,  // out_value, out_max, found_position, count
  output logic      [1:0]  out_tuser   // status[1:0]
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned PW   = sle_pkg::POS_W;
  localparam int unsigned CMPW = ((CW > PW) ? CW : PW) + 1;

  // Sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS      = 3'd1;
  localparam logic [2:0] S_INS_LAST = 3'd2;
  localparam logic [2:0] S_DEL      = 3'd3;
  localparam logic [2:0] S_SCAN     = 3'd4;
  localparam logic [2:0] S_REV      = 3'd5;
  localparam logic [2:0] S_FIN      = 3'd6;

  // Reverse sub-phases
  localparam logic [1:0] P_RD_A  = 2'd0;
  localparam logic [1:0] P_RD_B  = 2'd1;
  localparam logic [1:0] P_WR_A  = 2'd2;
  localparam logic [1:0] P_WR_B  = 2'd3;

  // Control state
  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;

  // Request context and walk state
  sle_pkg::req_t     kind_r, kind_nxt;
  sle_pkg::status_t stat_r, stat_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  sle_pkg::word_t    val_r, val_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     bidx_r, bidx_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic              rv_r, rv_nxt;
  logic [AW-1:0]     ra_r, ra_nxt;
  sle_pkg::word_t    tmp_r, tmp_nxt;
  sle_pkg::word_t    oval_r, oval_nxt;
  sle_pkg::word_t    omax_r, omax_nxt;
  logic [CW-1:0]     found_r, found_nxt;

  // Output payload
  logic [79:0]       out_tdata_r, out_tdata_nxt;
  logic [1:0]        out_tuser_r, out_tuser_nxt;

  // RAM port
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  sle_pkg::word_t    ram_wdata, ram_rdata;

  // Input field decode
  sle_pkg::req_t     in_kind;
  logic [PW-1:0]     in_pos;
  sle_pkg::word_t    in_val;
  logic [CMPW-1:0]   pos_w, cnt_w;
  logic              in_fire;

  // Result assembly
  logic [CW-1:0]     cnt_fin;
  logic [CW+PW-1:0]  cnt_ext, found_ext;

  assign in_kind = in_tuser;
  assign in_pos  = in_tdata[5:0];
  assign in_val  = in_tdata[37:6];
  assign pos_w   = CMPW'(in_pos);
  assign cnt_w   = CMPW'(cnt_r);

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Entry count after the request finishes
  always_comb begin
    cnt_fin = cnt_r;
    if (stat_r == sle_pkg::STAT_OK && kind_r == sle_pkg::REQ_INSERT) begin
      cnt_fin = cnt_r + CW'(1);
    end else if (stat_r == sle_pkg::STAT_OK && kind_r == sle_pkg::REQ_DELETE) begin
      cnt_fin = cnt_r - CW'(1);
    end
  end

  assign cnt_ext   = {{PW{1'b0}}, cnt_fin};
  assign found_ext = {{PW{1'b0}}, found_r};

  // List storage
  sle_ram #(
    .WIDTH (sle_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: accept, walk the RAM, then publish the result beat
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    out_tvalid_nxt = out_tvalid_r;
    kind_nxt       = kind_r;
    stat_nxt       = stat_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    bidx_nxt       = bidx_r;
    ph_nxt         = ph_r;
    rv_nxt         = 1'b0;
    ra_nxt         = ra_r;
    tmp_nxt        = tmp_r;
    oval_nxt       = oval_r;
    omax_nxt       = omax_r;
    found_nxt      = found_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = val_r;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    // Drop the result beat once taken
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt  = in_kind;
          val_nxt   = in_val;
          pos_nxt   = AW'(pos_w - CMPW'(1));
          stat_nxt  = sle_pkg::STAT_OK;
          oval_nxt  = '0;
          omax_nxt  = '0;
          found_nxt = '0;
          idx_nxt   = '0;
          bidx_nxt  = cnt_r - CW'(1);
          ph_nxt    = P_RD_A;
          state_nxt = S_FIN;
          if (in_kind == sle_pkg::REQ_INSERT) begin
            if (cnt_r >= CW'(CAPACITY)) begin
              stat_nxt = sle_pkg::STAT_FULL;
            end else if (pos_w == '0 || pos_w > cnt_w + CMPW'(1)) begin
              stat_nxt = sle_pkg::STAT_RANGE;
            end else begin
              idx_nxt   = cnt_r;
              state_nxt = S_INS;
            end
          end else if ((in_kind inside {sle_pkg::REQ_DELETE, sle_pkg::REQ_LOCATE,
                                         sle_pkg::REQ_MINMAX, sle_pkg::REQ_REVERSE})
                       && cnt_r == '0) begin
            stat_nxt = sle_pkg::STAT_EMPTY;
          end else begin
            case (in_kind)
              sle_pkg::REQ_DELETE: begin
                if (pos_w == '0 || pos_w > cnt_w) begin
                  stat_nxt = sle_pkg::STAT_RANGE;
                end else begin
                  idx_nxt   = CW'(pos_w - CMPW'(1));
                  state_nxt = S_DEL;
                end
              end
              sle_pkg::REQ_LOCATE,
              sle_pkg::REQ_MINMAX: begin
                state_nxt = S_SCAN;
              end
              sle_pkg::REQ_REVERSE: begin
                state_nxt = S_REV;
              end
              default: begin
                state_nxt = S_FIN;
              end
            endcase
          end
        end
      end

      // Shift entries up, highest first: read j-1, write it to j next cycle
      S_INS: begin
        if (rv_r) begin
          ram_we    = 1'b1;
          ram_waddr = ra_r + AW'(1);
          ram_wdata = ram_rdata;
        end
        if (idx_r > CW'(pos_r)) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(idx_r - CW'(1));
          ra_nxt    = AW'(idx_r - CW'(1));
          rv_nxt    = 1'b1;
          idx_nxt   = idx_r - CW'(1);
        end else begin
          state_nxt = S_INS_LAST;
        end
      end

      // Drop the new value into the opened slot
      S_INS_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = val_r;
        state_nxt = S_FIN;
      end

      // Capture the removed entry, then shift later entries down
      S_DEL: begin
        if (rv_r) begin
          if (ra_r == pos_r) begin
            oval_nxt = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = ra_r - AW'(1);
            ram_wdata = ram_rdata;
          end
        end
        if (idx_r < cnt_r) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(idx_r);
          ra_nxt    = AW'(idx_r);
          rv_nxt    = 1'b1;
          idx_nxt   = idx_r + CW'(1);
        end else begin
          state_nxt = S_FIN;
        end
      end

      // Walk all entries for locate or minmax
      S_SCAN: begin
        if (rv_r) begin
          if (kind_r == sle_pkg::REQ_LOCATE) begin
            if (ram_rdata == val_r && found_r == '0) begin
              found_nxt = CW'(ra_r) + CW'(1);
            end
          end else if (ra_r == '0) begin
            oval_nxt = ram_rdata;
            omax_nxt = ram_rdata;
          end else begin
            if ($signed(ram_rdata) < $signed(oval_r)) begin
              oval_nxt = ram_rdata;
            end
            if ($signed(ram_rdata) > $signed(omax_r)) begin
              omax_nxt = ram_rdata;
            end
          end
        end
        if (idx_r < cnt_r) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(idx_r);
          ra_nxt    = AW'(idx_r);
          rv_nxt    = 1'b1;
          idx_nxt   = idx_r + CW'(1);
        end else begin
          state_nxt = S_FIN;
        end
      end

      // Swap the outer pair, then step both ends inward
      S_REV: begin
        case (ph_r)
          P_RD_A: begin
            if (idx_r < bidx_r) begin
              ram_re    = 1'b1;
              ram_raddr = AW'(idx_r);
              ph_nxt    = P_RD_B;
            end else begin
              state_nxt = S_FIN;
            end
          end
          P_RD_B: begin
            ram_re    = 1'b1;
            ram_raddr = AW'(bidx_r);
            tmp_nxt   = ram_rdata;
            ph_nxt    = P_WR_A;
          end
          P_WR_A: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(idx_r);
            ram_wdata = ram_rdata;
            ph_nxt    = P_WR_B;
          end
          P_WR_B: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(bidx_r);
            ram_wdata = tmp_r;
            idx_nxt   = idx_r + CW'(1);
            bidx_nxt  = bidx_r - CW'(1);
            ph_nxt    = P_RD_A;
          end
          default: begin
            ph_nxt = P_RD_A;
          end
        endcase
      end

      // Hold until the output register is free, then publish
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = stat_r;
          out_tdata_nxt  = {4'b0, cnt_ext[PW-1:0], found_ext[PW-1:0], omax_r, oval_r};
          cnt_nxt        = cnt_fin;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
      rv_r         <= 1'b0;
      ph_r         <= P_RD_A;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      rv_r         <= rv_nxt;
      ph_r         <= ph_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    stat_r      <= stat_nxt;
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    idx_r       <= idx_nxt;
    bidx_r      <= bidx_nxt;
    ra_r        <= ra_nxt;
    tmp_r       <= tmp_nxt;
    oval_r      <= oval_nxt;
    omax_r      <= omax_nxt;
    found_r     <= found_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

`ifndef SYNTHESIS
  // Entry count never exceeds the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // No RAM write while idle
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r != S_IDLE))
    else $error("RAM write while idle");

  // An accepted beat makes the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready stayed high after accept");

  // A result beat appears only out of the finish state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == S_FIN))
    else $error("result beat raised outside finish");

  // Entry count changes only when a result is published
  a_cnt_at_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> ($past(state_r) == S_FIN))
    else $error("entry count changed outside finish");
`endif

endmodule

`default_nettype wire
